/* hw/rtl/cnc_link_receive_parser_defines.svh */
// Assertion helpers for the link receive parser.
`ifndef CNC_LINK_RECEIVE_PARSER_DEFINES_SVH
`define CNC_LINK_RECEIVE_PARSER_DEFINES_SVH

// Checked on every clock edge, held off while reset is asserted.
`define CNCLRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CNCLRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/cnclrp_pkg.sv */
package cnclrp_pkg;

  localparam int ByteW          = 8;
  localparam int LenW           = 7;
  localparam int MaxFrameLenDef = 64;

  localparam logic [LenW-1:0] LenReset = LenW'(8);

  localparam logic [ByteW-1:0] CharK  = 8'h4B;
  localparam logic [ByteW-1:0] CharF  = 8'h46;
  localparam logic [ByteW-1:0] CharR  = 8'h52;
  localparam logic [ByteW-1:0] CharE  = 8'h45;
  localparam logic [ByteW-1:0] CharT  = 8'h54;
  localparam logic [ByteW-1:0] CharNl = 8'h0A;

  typedef enum logic [2:0] {
    KIND_CMD    = 3'd0,
    KIND_REPEAT = 3'd1,
    KIND_ACK    = 3'd2,
    KIND_ECHO   = 3'd3,
    KIND_TELEM  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ECHO  = 2'd1,
    MODE_TELEM = 2'd2
  } mode_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic             last;
    logic             ok;
  } result_t;

endpackage

/* hw/rtl/cnclrp_skid.sv */
module cnclrp_skid import cnclrp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] in_data_i,
  output logic             valid_o,
  output logic [ByteW-1:0] data_o,
  input  logic             pop_i
);

  logic             main_valid_q, skid_valid_q;
  logic [ByteW-1:0] main_data_q, skid_data_q;
  logic             accept;

  // stall is purely registered; the skid entry absorbs the transfer in flight
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign valid_o    = main_valid_q;
  assign data_o     = main_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop_i && main_valid_q) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (!accept) begin
        main_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!main_valid_q) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i && main_valid_q) begin
      if (skid_valid_q) begin
        main_data_q <= skid_data_q;
      end else if (accept) begin
        main_data_q <= in_data_i;
      end
    end else if (accept) begin
      if (!main_valid_q) begin
        main_data_q <= in_data_i;
      end else begin
        skid_data_q <= in_data_i;
      end
    end
  end

endmodule

/* hw/rtl/cnclrp_core.sv */
`include "cnc_link_receive_parser_defines.svh"

module cnclrp_core import cnclrp_pkg::*; #(
  parameter int MAX_FRAME_LEN = MaxFrameLenDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LenW-1:0]  cfg_data_i,
  input  logic             fire_i,
  input  logic [ByteW-1:0] byte_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  localparam int CntW = $clog2(MAX_FRAME_LEN + 3);
  localparam int CmpW = (CntW > LenW) ? CntW : LenW;

  logic [LenW-1:0]  len_q;
  mode_e            mode_q, mode_d;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_inc, frame_n;
  logic [15:0]      sum_q, sum_d;
  logic [ByteW-1:0] csum_lo_q, csum_lo_d;
  logic [CmpW-1:0]  len_ext, max_ext, n_wide;
  logic             frame_end;

  // length clamped to 1..MAX_FRAME_LEN
  assign len_ext = CmpW'(len_q);
  assign max_ext = CmpW'(MAX_FRAME_LEN);
  always_comb begin
    if (len_ext == '0) begin
      n_wide = CmpW'(1);
    end else if (len_ext > max_ext) begin
      n_wide = max_ext;
    end else begin
      n_wide = len_ext;
    end
  end
  assign frame_n   = CntW'(n_wide);
  assign cnt_inc   = cnt_q + CntW'(1);
  assign frame_end = (cnt_inc >= frame_n + CntW'(2));

  always_comb begin
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    csum_lo_d   = csum_lo_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_CMD, data: '0, last: 1'b0, ok: 1'b0};
    case (mode_q)
      MODE_IDLE: begin
        case (byte_i)
          CharK: begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_CMD;
          end
          CharF: begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_REPEAT;
          end
          CharR: begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_ACK;
          end
          CharE: begin
            mode_d = MODE_ECHO;
            cnt_d  = '0;
          end
          CharT: begin
            mode_d = MODE_TELEM;
            cnt_d  = '0;
            sum_d  = '0;
          end
          default: begin
          end
        endcase
      end
      MODE_ECHO: begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_ECHO;
        res_o.data  = byte_i;
        if (byte_i == CharNl) begin
          mode_d     = MODE_IDLE;
          res_o.last = 1'b1;
        end
      end
      MODE_TELEM: begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_TELEM;
        res_o.data  = byte_i;
        cnt_d       = cnt_inc;
        if (cnt_inc <= frame_n) begin
          sum_d = sum_q + 16'(byte_i);
        end else if (cnt_inc == frame_n + CntW'(1)) begin
          csum_lo_d = byte_i;
        end
        if (frame_end) begin
          // checksum arrives low byte first
          mode_d     = MODE_IDLE;
          cnt_d      = '0;
          res_o.last = 1'b1;
          res_o.ok   = ({byte_i, csum_lo_q} == sum_q);
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        cnt_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= LenReset;
      mode_q    <= MODE_IDLE;
      cnt_q     <= '0;
      sum_q     <= '0;
      csum_lo_q <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
      if (fire_i) begin
        mode_q    <= mode_d;
        cnt_q     <= cnt_d;
        sum_q     <= sum_d;
        csum_lo_q <= csum_lo_d;
      end
    end
  end

  `CNCLRP_ASSERT(a_cnt_only_in_frame,
                 (cnt_q != '0) |-> (mode_q == MODE_TELEM),
                 "byte count set outside a telemetry frame")
  `CNCLRP_ASSERT(a_cnt_bounded,
                 (mode_q == MODE_TELEM) |-> (cnt_q <= CntW'(MAX_FRAME_LEN + 1)),
                 "telemetry byte count past frame end")
  `CNCLRP_ASSERT(a_last_returns_idle,
                 (fire_i && res_valid_o && res_o.last) |=> (mode_q == MODE_IDLE),
                 "parser not idle after last transfer")

endmodule

/* hw/rtl/cnclrp_out_reg.sv */
module cnclrp_out_reg import cnclrp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  assign ready_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule

/* hw/rtl/cnc_link_receive_parser.sv */
// Link receive parser: takes one received byte per transfer and sustains one
// byte per clock while the sink does not stall. Each accepted byte passes a
// two-entry input buffer (stall is registered there) and one decode step. Its
// event, if any, is then loaded into the output register; a stalling sink holds
// bytes in the buffer. 'K', 'F', 'R' give single events, 'E' opens an echo line
// closed by newline, 'T' opens a telemetry frame of telemetry_len payload bytes
// (clamped to 1..MAX_FRAME_LEN) plus a little-endian 16-bit sum. Other idle bytes
// produce nothing. Write telemetry_len only while no byte is buffered or in decode;
// a new length set mid-frame applies from the next byte of that frame.
module cnc_link_receive_parser import cnclrp_pkg::*; #(
  parameter int MAX_FRAME_LEN = MaxFrameLenDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LenW-1:0]  cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       event_kind_o,
  output logic [ByteW-1:0] payload_o,
  output logic             last_o,
  output logic             checksum_ok_o
);

  logic             buf_valid, fire, res_valid, out_ready;
  logic [ByteW-1:0] buf_data;
  result_t          res, out_res;

  assign fire = buf_valid && out_ready;

  cnclrp_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (rx_byte_i),
    .valid_o    (buf_valid),
    .data_o     (buf_data),
    .pop_i      (out_ready)
  );

  cnclrp_core #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .byte_i      (buf_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cnclrp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && res_valid),
    .res_i   (res),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (out_res)
  );

  assign event_kind_o  = out_res.kind;
  assign payload_o     = out_res.data;
  assign last_o        = out_res.last;
  assign checksum_ok_o = out_res.ok;

endmodule
